// File: rtl/core/load_store_request_tracker_macros.svh
// assertion macros for the load/store request tracker
`ifndef LOAD_STORE_REQUEST_TRACKER_MACROS_SVH
`define LOAD_STORE_REQUEST_TRACKER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define LSRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LSRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lsrt_pkg.sv
// shared types and constants of the load/store request tracker
`timescale 1ns / 1ps

package lsrt_pkg;

  localparam int CARRIED_LANES = 4;
  localparam int LANE_W        = 2;
  localparam int ADDR_W        = 32;
  localparam int ID_W          = 16;
  localparam int TAG_W         = 3;
  localparam int KIND_W        = 3;
  localparam int CMD_W         = 2;
  localparam int SPACE_W       = 2;
  localparam int REM_W         = 3;

  // byte offset within a 32-bit word
  localparam logic [ADDR_W-1:0] WORD_OFFSET_MASK = ADDR_W'(4 - 1);

  localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STORE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FENCE    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESPONSE = 2'd3;

  localparam logic [KIND_W-1:0] KIND_CACHE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SHARED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DONE   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BUSY   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STRAY  = 3'd4;

  localparam logic [SPACE_W-1:0] SPACE_SHARED = 2'd1;
  localparam logic [SPACE_W-1:0] SPACE_IO     = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]                 command;
    logic [CARRIED_LANES-1:0]         lane_mask;
    logic [ADDR_W-1:0]                lane0_address;
    logic [ADDR_W-1:0]                lane1_address;
    logic [ADDR_W-1:0]                lane2_address;
    logic [ADDR_W-1:0]                lane3_address;
    logic [SPACE_W*CARRIED_LANES-1:0] lane_spaces;
    logic [ID_W-1:0]                  instr_id;
    logic [TAG_W-1:0]                 response_tag;
  } lsrt_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LANE_W-1:0] lane;
    logic [ADDR_W-1:0] address;
    logic              store_req;
    logic              uncached;
    logic [TAG_W-1:0]  tag;
    logic [ID_W-1:0]   done_id;
    logic              last;
  } lsrt_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FENCE_DONE,
    ST_LANES,
    ST_FINISH
  } lsrt_state_t;

  typedef enum logic [2:0] {
    EMIT_STRAY,
    EMIT_LOAD_DONE,
    EMIT_FENCE_DONE,
    EMIT_BUSY,
    EMIT_FENCE_NOW,
    EMIT_LANE,
    EMIT_ACCESS_DONE
  } lsrt_emit_t;

  typedef struct packed {
    logic       capture;
    logic       emit;
    lsrt_emit_t emit_sel;
    logic       emit_last;
    logic       setup;
    logic       write_rem;
    logic       clear_entry;
    logic       alloc_entry;
    logic       fence_set;
    logic       fence_clear;
  } lsrt_cmd_t;

  typedef struct packed {
    logic             out_free;
    logic [CMD_W-1:0] command;
    logic             resp_hit;
    logic             rem_zero;
    logic             empty_after;
    logic             table_empty;
    logic             any_free;
    logic             fence_waiting;
    logic             pend_empty;
    logic             pend_single;
    logic             count_zero;
    logic             is_store;
    logic             entry_any;
  } lsrt_status_t;

endpackage

// File: rtl/core/load_store_request_tracker.sv
// top level of the load/store request tracker: sequencer plus table datapath
// one item at a time: taken in idle, decoded next cycle; response, fence and busy results
// come from decode, a freed fence's completion from its own state; a load with n requests
// (1 after same-word merging) ends on its last request, a store or an empty mask on a done
// result; requests go out one per cycle unless the result stalls, which holds the sequencer
// and input; synchronous reset clears the valid bits, fence flag, state and result valid
`timescale 1ns / 1ps
`include "load_store_request_tracker_macros.svh"

module load_store_request_tracker
  import lsrt_pkg::*;
#(
  parameter int TABLE_DEPTH = 8,
  parameter int NUM_LANES   = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  lsrt_item_t   item,
  output logic         result_valid,
  input  logic         result_stall,
  output lsrt_result_t result
);

  // command and status between the sequencer and the datapath
  lsrt_cmd_t    cmd;
  lsrt_status_t stat;
  lsrt_state_t  state;

  // sequencer: decode, busy and fence decisions, one lane request per cycle while the result is free
  lsrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .stat      (stat),
    .cmd       (cmd),
    .state     (state)
  );

  // datapath: pending table (valid flops, count/id ram), fence register,
  // lane merge logic and the result register
  lsrt_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .NUM_LANES  (NUM_LANES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cmd         (cmd),
    .stat        (stat),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  logic beat_in;
  logic last_out;
  logic fence_held;
  assign beat_in    = item_valid && !item_stall;
  assign last_out   = cmd.emit && cmd.emit_last;
  assign fence_held = stat.fence_waiting && (state != ST_FENCE_DONE);

  // an accepted beat always goes to decode
  `LSRT_ASSERT_NEXT(a_accept_decode, beat_in, state == ST_DECODE, "accepted beat skipped decode")

  // the beat marked last ends the item
  `LSRT_ASSERT_NEXT(a_last_idle, last_out, state == ST_IDLE, "last beat did not end the item")

  // a waiting fence implies outstanding loads, except while its completion goes out
  `LSRT_ASSERT_NOW(a_fence_pending, fence_held, stat.entry_any, "fence waits on empty table")

endmodule

// File: rtl/core/lsrt_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module lsrt_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/lsrt_ctrl.sv
// sequencing state machine of the load/store request tracker
`timescale 1ns / 1ps

module lsrt_ctrl
  import lsrt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  lsrt_status_t stat,
  output lsrt_cmd_t    cmd,
  output lsrt_state_t  state
);

  lsrt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign item_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        priority if (stat.command == CMD_RESPONSE) begin
          priority if (!stat.resp_hit) begin
            if (stat.out_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_sel  = EMIT_STRAY;
              cmd.emit_last = 1'b1;
              state_next    = ST_IDLE;
            end
          end else if (!stat.rem_zero) begin
            cmd.write_rem = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            if (stat.out_free) begin
              cmd.emit        = 1'b1;
              cmd.emit_sel    = EMIT_LOAD_DONE;
              cmd.clear_entry = 1'b1;
              if (stat.fence_waiting && stat.empty_after) begin
                state_next = ST_FENCE_DONE;
              end else begin
                cmd.emit_last = 1'b1;
                state_next    = ST_IDLE;
              end
            end
          end
        end else if (stat.fence_waiting || (stat.command != CMD_FENCE && !stat.any_free)) begin
          if (stat.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = EMIT_BUSY;
            cmd.emit_last = 1'b1;
            state_next    = ST_IDLE;
          end
        end else if (stat.command == CMD_FENCE) begin
          if (stat.table_empty) begin
            if (stat.out_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_sel  = EMIT_FENCE_NOW;
              cmd.emit_last = 1'b1;
              state_next    = ST_IDLE;
            end
          end else begin
            cmd.fence_set = 1'b1;
            state_next    = ST_IDLE;
          end
        end else begin
          cmd.setup  = 1'b1;
          state_next = ST_LANES;
        end
      end
      ST_FENCE_DONE: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_sel    = EMIT_FENCE_DONE;
          cmd.emit_last   = 1'b1;
          cmd.fence_clear = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_LANES: begin
        if (stat.pend_empty) begin
          state_next = ST_FINISH;
        end else if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_LANE;
          if (stat.pend_single) begin
            if (!stat.is_store && !stat.count_zero) begin
              cmd.emit_last   = 1'b1;
              cmd.alloc_entry = 1'b1;
              state_next      = ST_IDLE;
            end else begin
              state_next = ST_FINISH;
            end
          end
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EMIT_ACCESS_DONE;
          cmd.emit_last = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/lsrt_datapath.sv
// pending table, fence register, lane sequencing and result register
`timescale 1ns / 1ps

module lsrt_datapath
  import lsrt_pkg::*;
#(
  parameter int TABLE_DEPTH = 8,
  parameter int NUM_LANES   = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  lsrt_item_t   item,
  input  lsrt_cmd_t    cmd,
  output lsrt_status_t stat,
  output logic         result_valid,
  input  logic         result_stall,
  output lsrt_result_t result
);

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int LANES   = (NUM_LANES < CARRIED_LANES) ? NUM_LANES : CARRIED_LANES;
  localparam int ENTRY_W = REM_W + ID_W;
  localparam logic [CARRIED_LANES-1:0] LANE_EN = CARRIED_LANES'((1 << LANES) - 1);

  // captured item and per-access state
  lsrt_item_t                       cur;
  logic [IDX_W-1:0]                 alloc_tag;
  logic [CARRIED_LANES-1:0]         pend;
  logic [REM_W-1:0]                 count;

  // table state
  logic [TABLE_DEPTH-1:0]           valid;
  logic [IDX_W-1:0]                 free_idx;
  logic                             any_free;
  logic                             table_empty;
  logic                             fence_waiting;
  logic [ID_W-1:0]                  fence_instr;

  logic                             out_valid;
  lsrt_result_t                     out_data;

  logic                             out_free;
  logic [IDX_W-1:0]                 rtag_idx;
  logic                             in_range;
  logic [ENTRY_W-1:0]               rdata;
  logic [REM_W-1:0]                 rem;
  logic [REM_W-1:0]                 rem_dec;
  logic [ID_W-1:0]                  ent_instr;
  logic [TABLE_DEPTH-1:0]           hit_onehot;
  logic                             ram_we;
  logic [IDX_W-1:0]                 ram_waddr;
  logic [ENTRY_W-1:0]               ram_wdata;
  logic [IDX_W-1:0]                 ram_raddr;

  logic [CARRIED_LANES-1:0][ADDR_W-1:0] lane_addr;
  logic [CARRIED_LANES-1:0]         mask;
  logic [REM_W-1:0]                 active;
  logic                             dup;
  logic [IDX_W-1:0]                 free_c;
  logic [LANE_W-1:0]                low_lane;
  logic [SPACE_W-1:0]               low_space;
  lsrt_result_t                     emit_data;

  assign out_free = !out_valid || !result_stall;

  // pending table payload: outstanding count and instruction id
  assign rtag_idx  = IDX_W'(cur.response_tag);
  assign in_range  = (32'(cur.response_tag) < TABLE_DEPTH);
  assign rem       = rdata[ENTRY_W-1 -: REM_W];
  assign ent_instr = rdata[ID_W-1:0];
  assign rem_dec   = (rem != '0) ? rem - REM_W'(1) : '0;
  assign hit_onehot = TABLE_DEPTH'(1) << rtag_idx;

  assign ram_raddr = cmd.capture ? IDX_W'(item.response_tag) : rtag_idx;
  assign ram_we    = cmd.write_rem || cmd.alloc_entry;
  assign ram_waddr = cmd.write_rem ? rtag_idx : alloc_tag;
  assign ram_wdata = cmd.write_rem ? {rem_dec, ent_instr} : {count, cur.instr_id};

  lsrt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  // lowest free tag
  always_comb begin
    free_c = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_c = IDX_W'(i);
      end
    end
  end

  // lane mask, active count and same-word detection
  assign lane_addr[0] = cur.lane0_address;
  assign lane_addr[1] = cur.lane1_address;
  assign lane_addr[2] = cur.lane2_address;
  assign lane_addr[3] = cur.lane3_address;
  assign mask = cur.lane_mask & LANE_EN;

  always_comb begin
    active = '0;
    dup    = mask[0];
    for (int t = 0; t < CARRIED_LANES; t++) begin
      active = active + REM_W'(mask[t]);
    end
    for (int t = 1; t < CARRIED_LANES; t++) begin
      if (mask[t] && ((lane_addr[t] & ~WORD_OFFSET_MASK) !=
                      (lane_addr[0] & ~WORD_OFFSET_MASK))) begin
        dup = 1'b0;
      end
    end
  end

  always_comb begin
    low_lane = '0;
    for (int t = CARRIED_LANES - 1; t >= 0; t--) begin
      if (pend[t]) begin
        low_lane = LANE_W'(t);
      end
    end
  end

  assign low_space = cur.lane_spaces[{low_lane, 1'b0} +: SPACE_W];

  always_comb begin
    emit_data      = '0;
    emit_data.last = cmd.emit_last;
    unique case (cmd.emit_sel)
      EMIT_STRAY: begin
        emit_data.kind = KIND_STRAY;
        emit_data.tag  = cur.response_tag;
      end
      EMIT_LOAD_DONE: begin
        emit_data.kind    = KIND_DONE;
        emit_data.tag     = cur.response_tag;
        emit_data.done_id = ent_instr;
      end
      EMIT_FENCE_DONE: begin
        emit_data.kind    = KIND_DONE;
        emit_data.done_id = fence_instr;
      end
      EMIT_BUSY: begin
        emit_data.kind    = KIND_BUSY;
        emit_data.done_id = cur.instr_id;
      end
      EMIT_FENCE_NOW: begin
        emit_data.kind    = KIND_DONE;
        emit_data.done_id = cur.instr_id;
      end
      EMIT_LANE: begin
        emit_data.kind      = (low_space == SPACE_SHARED) ? KIND_SHARED : KIND_CACHE;
        emit_data.lane      = low_lane;
        emit_data.address   = lane_addr[low_lane];
        emit_data.store_req = (cur.command == CMD_STORE);
        emit_data.uncached  = (low_space == SPACE_IO);
        emit_data.tag       = TAG_W'(alloc_tag);
      end
      EMIT_ACCESS_DONE: begin
        emit_data.kind    = KIND_DONE;
        emit_data.tag     = TAG_W'(alloc_tag);
        emit_data.done_id = cur.instr_id;
      end
      default: begin
        emit_data.kind = KIND_STRAY;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      fence_waiting <= 1'b0;
      out_valid     <= 1'b0;
      any_free      <= 1'b1;
      table_empty   <= 1'b1;
      free_idx      <= '0;
    end else begin
      any_free    <= ~&valid;
      table_empty <= ~|valid;
      free_idx    <= free_c;
      if (cmd.clear_entry) begin
        valid[rtag_idx] <= 1'b0;
      end
      if (cmd.alloc_entry) begin
        valid[alloc_tag] <= 1'b1;
      end
      if (cmd.fence_set) begin
        fence_waiting <= 1'b1;
      end else if (cmd.fence_clear) begin
        fence_waiting <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!result_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= item;
    end
    if (cmd.fence_set) begin
      fence_instr <= cur.instr_id;
    end
    if (cmd.setup) begin
      alloc_tag <= free_idx;
      pend      <= dup ? CARRIED_LANES'(1) : mask;
      count     <= dup ? REM_W'(1) : active;
    end else if (cmd.emit && (cmd.emit_sel == EMIT_LANE)) begin
      pend[low_lane] <= 1'b0;
    end
    if (cmd.emit) begin
      out_data <= emit_data;
    end
  end

  assign result_valid = out_valid;
  assign result       = out_data;

  always_comb begin
    stat               = '0;
    stat.out_free      = out_free;
    stat.command       = cur.command;
    stat.resp_hit      = in_range && valid[rtag_idx];
    stat.rem_zero      = (rem_dec == '0);
    stat.empty_after   = ((valid & ~hit_onehot) == '0);
    stat.table_empty   = table_empty;
    stat.any_free      = any_free;
    stat.fence_waiting = fence_waiting;
    stat.pend_empty    = (pend == '0);
    stat.pend_single   = (pend != '0) && ((pend & (pend - CARRIED_LANES'(1))) == '0);
    stat.count_zero    = (count == '0);
    stat.is_store      = (cur.command == CMD_STORE);
    stat.entry_any     = |valid;
  end

endmodule

// File: bench/load_store_request_tracker_checker.sv
// channel monitor, pending-table predictor and result comparator for the request tracker
`timescale 1ns / 1ps

module load_store_request_tracker_checker
  import lsrt_pkg::*;
#(
  parameter int TABLE_DEPTH = 8,
  parameter int NUM_LANES   = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  logic         item_stall,
  input  lsrt_item_t   item,
  input  logic         result_valid,
  input  logic         result_stall,
  input  lsrt_result_t result,
  output int           fail_count,
  output int           owed_count
);

  // shadow of the pending table
  logic             slot_busy  [TABLE_DEPTH];
  logic [REM_W-1:0] slot_left  [TABLE_DEPTH];
  logic [ID_W-1:0]  slot_instr [TABLE_DEPTH];
  logic             fence_pending;
  logic [ID_W-1:0]  fence_id;

  lsrt_result_t owed_results[$];
  lsrt_result_t want;
  int           errors = 0;

  function automatic lsrt_result_t make_beat(input logic [KIND_W-1:0] kind,
                                             input int lane,
                                             input logic [ADDR_W-1:0] addr,
                                             input logic wr, input logic nc,
                                             input int tag,
                                             input logic [ID_W-1:0] id);
    lsrt_result_t r;
    r.kind      = kind;
    r.lane      = LANE_W'(lane);
    r.address   = addr;
    r.store_req = wr;
    r.uncached  = nc;
    r.tag       = TAG_W'(tag);
    r.done_id   = id;
    r.last      = 1'b0;
    return r;
  endfunction

  function automatic bit table_drained();
    bit drained;
    drained = 1'b1;
    foreach (slot_busy[s]) if (slot_busy[s]) drained = 1'b0;
    return drained;
  endfunction

  task automatic predict_tracker(input lsrt_item_t it);
    logic [ADDR_W-1:0]        addr [CARRIED_LANES];
    logic [CARRIED_LANES-1:0] mask;
    logic [SPACE_W-1:0]       sp;
    lsrt_result_t             r;
    int                       lanes, slot, active, same_word, first, t;
    bit                       merged, write;

    first   = owed_results.size();
    lanes   = NUM_LANES < CARRIED_LANES ? NUM_LANES : CARRIED_LANES;
    addr[0] = it.lane0_address;
    addr[1] = it.lane1_address;
    addr[2] = it.lane2_address;
    addr[3] = it.lane3_address;
    mask    = it.lane_mask;
    for (t = lanes; t < CARRIED_LANES; t++) mask[t] = 1'b0;

    if (it.command == CMD_RESPONSE) begin
      slot = int'(it.response_tag);
      if (slot >= TABLE_DEPTH || !slot_busy[slot]) begin
        owed_results.push_back(make_beat(KIND_STRAY, 0, '0, 1'b0, 1'b0, slot, '0));
      end else begin
        if (slot_left[slot] != '0) slot_left[slot] = slot_left[slot] - 1'b1;
        if (slot_left[slot] == '0) begin
          owed_results.push_back(make_beat(KIND_DONE, 0, '0, 1'b0, 1'b0, slot,
                                           slot_instr[slot]));
          slot_busy[slot] = 1'b0;
        end
        // last load out releases a waiting fence
        if (fence_pending && table_drained()) begin
          owed_results.push_back(make_beat(KIND_DONE, 0, '0, 1'b0, 1'b0, 0, fence_id));
          fence_pending = 1'b0;
        end
      end
    end else if (fence_pending) begin
      owed_results.push_back(make_beat(KIND_BUSY, 0, '0, 1'b0, 1'b0, 0, it.instr_id));
    end else if (it.command == CMD_FENCE) begin
      if (table_drained()) begin
        owed_results.push_back(make_beat(KIND_DONE, 0, '0, 1'b0, 1'b0, 0, it.instr_id));
      end else begin
        fence_pending = 1'b1;
        fence_id      = it.instr_id;
      end
    end else begin
      slot = -1;
      for (t = 0; t < TABLE_DEPTH; t++) if (!slot_busy[t] && slot < 0) slot = t;
      if (slot < 0) begin
        owed_results.push_back(make_beat(KIND_BUSY, 0, '0, 1'b0, 1'b0, 0, it.instr_id));
      end else begin
        write  = (it.command == CMD_STORE);
        active = 0;
        for (t = 0; t < lanes; t++) if (mask[t]) active++;
        merged = 1'b0;
        if (mask[0]) begin
          same_word = 1;
          for (t = 1; t < lanes; t++)
            if (mask[t] && (addr[t] & ~WORD_OFFSET_MASK) == (addr[0] & ~WORD_OFFSET_MASK))
              same_word++;
          merged = (same_word == active);
        end
        for (t = 0; t < lanes; t++) begin
          if (mask[t] && !(merged && t > 0)) begin
            sp = it.lane_spaces[SPACE_W*t +: SPACE_W];
            owed_results.push_back(make_beat(sp == SPACE_SHARED ? KIND_SHARED : KIND_CACHE,
                                             t, addr[t], write, sp == SPACE_IO, slot, '0));
          end
        end
        if (write || active == 0) begin
          owed_results.push_back(make_beat(KIND_DONE, 0, '0, 1'b0, 1'b0, slot, it.instr_id));
        end else begin
          slot_busy[slot]  = 1'b1;
          slot_left[slot]  = REM_W'(merged ? 1 : active);
          slot_instr[slot] = it.instr_id;
        end
      end
    end

    if (owed_results.size() > first) begin
      r = owed_results[owed_results.size() - 1];
      r.last = 1'b1;
      owed_results[owed_results.size() - 1] = r;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (slot_busy[s]) slot_busy[s] = 1'b0;
      fence_pending = 1'b0;
      owed_results.delete();
    end else begin
      if (item_valid && !item_stall) predict_tracker(item);
      if (result_valid && !result_stall) begin
        if (owed_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, actual %p", $time, result);
        end else begin
          want = owed_results.pop_front();
          if (result !== want) begin
            errors++;
            $display("%0t: mismatch kind %0d/%0d lane %0d/%0d addr %h/%h wr %b/%b nc %b/%b",
                     $time, want.kind, result.kind, want.lane, result.lane, want.address,
                     result.address, want.store_req, result.store_req, want.uncached,
                     result.uncached);
            $display("%0t:   tag %0d/%0d id %h/%h last %b/%b (expected/actual)", $time,
                     want.tag, result.tag, want.done_id, result.done_id, want.last,
                     result.last);
          end
        end
      end
    end
    owed_count <= owed_results.size();
    fail_count <= errors;
  end

endmodule

// File: bench/load_store_request_tracker_tb.sv
// stimulus and verdict for the load/store request tracker, with the checker beside the block
`timescale 1ns / 1ps

module load_store_request_tracker_tb;
  import lsrt_pkg::*;

  localparam int TABLE_DEPTH = 8;
  localparam int NUM_LANES   = 4;
  localparam int ITEMS       = 380;
  // long receiver hold-off, enough to fill the block and back up the input
  localparam int HOLD_CYCLES = 300;
  // idle stretch after the final drain, before the verdict
  localparam int TAIL_CYCLES = 20;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         item_valid;
  logic         item_stall;
  lsrt_item_t   item;
  logic         result_valid;
  logic         result_stall;
  lsrt_result_t result;
  int           fail_count;
  int           owed_count;

  // tags of load requests seen leaving the block, each owed one memory response
  logic [TAG_W-1:0] unanswered_tags[$];

  // stimulus shaping flags; steady and hold_off are shared with the receiver
  bit steady     = 1'b0;
  bit hold_off   = 1'b0;
  bit load_burst = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  load_store_request_tracker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .NUM_LANES  (NUM_LANES)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  load_store_request_tracker_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .NUM_LANES  (NUM_LANES)
  ) tracker_check (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .fail_count  (fail_count),
    .owed_count  (owed_count)
  );

  // run limit, far above the slowest legal run
  initial begin
    #3_000_000;
    $display("** load_store_request_tracker: FAILED **");
    $finish;
  end

  // receiver: random stalls, a quiet stretch, and one long hold-off on request
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off && !hold_taken) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_taken = 1'b1;
      end else begin
        result_stall <= !steady && ($urandom_range(99) < 35);
      end
    end
  end

  // every load request beat taken off the result channel owes a response
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall && !result.store_req &&
        (result.kind == KIND_CACHE || result.kind == KIND_SHARED))
      unanswered_tags.push_back(result.tag);
  end

  function automatic lsrt_item_t make_item(input logic [CMD_W-1:0] cmd,
                                           input logic [CARRIED_LANES-1:0] mask,
                                           input logic [ADDR_W-1:0] a0, a1, a2, a3,
                                           input logic [SPACE_W*CARRIED_LANES-1:0] spaces,
                                           input logic [ID_W-1:0] id,
                                           input logic [TAG_W-1:0] rtag);
    lsrt_item_t it;
    it.command       = cmd;
    it.lane_mask     = mask;
    it.lane0_address = a0;
    it.lane1_address = a1;
    it.lane2_address = a2;
    it.lane3_address = a3;
    it.lane_spaces   = spaces;
    it.instr_id      = id;
    it.response_tag  = rtag;
    return it;
  endfunction

  // random content; lanes often share lane 0's word so merging gets exercised
  function automatic lsrt_item_t random_item(input logic [CMD_W-1:0] cmd);
    lsrt_item_t        it;
    logic [ADDR_W-1:0] base;
    base = ADDR_W'($urandom);
    it   = make_item(cmd, CARRIED_LANES'($urandom), ADDR_W'($urandom), ADDR_W'($urandom),
                     ADDR_W'($urandom), ADDR_W'($urandom),
                     (SPACE_W*CARRIED_LANES)'($urandom), ID_W'($urandom), TAG_W'($urandom));
    if ($urandom_range(99) < 40) begin
      it.lane0_address = {base[ADDR_W-1:2], 2'($urandom)};
      it.lane1_address = {base[ADDR_W-1:2], 2'($urandom)};
      it.lane2_address = {base[ADDR_W-1:2], 2'($urandom)};
      it.lane3_address = {base[ADDR_W-1:2], 2'($urandom)};
      // now and then one lane strays to another word
      if ($urandom_range(3) == 0) it.lane2_address = base + ADDR_W'(4);
    end
    return it;
  endfunction

  // offer one beat, with random gaps first, and hold it until taken
  task automatic send(input lsrt_item_t it);
    while (!steady && $urandom_range(99) < 35) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // sender goes quiet until every predicted result beat has come out
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (owed_count != 0);
  endtask

  // directed response to one tag, dropping it from the owed list
  task automatic answer(input logic [TAG_W-1:0] tag);
    int hit;
    hit = -1;
    foreach (unanswered_tags[k]) if (hit < 0 && unanswered_tags[k] == tag) hit = k;
    if (hit >= 0) unanswered_tags.delete(hit);
    send(make_item(CMD_RESPONSE, '0, '0, '0, '0, '0, '0, '0, tag));
  endtask

  initial begin
    lsrt_item_t it;
    int         n, roll, idx;

    item_valid <= 1'b0;
    item       <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // fence with nothing pending finishes right away
    send(make_item(CMD_FENCE, '0, '0, '0, '0, '0, '0, 16'h0001, '0));
    // responses to empty slots come back as strays
    send(make_item(CMD_RESPONSE, '0, '0, '0, '0, '0, '0, '0, 3'd7));
    send(make_item(CMD_RESPONSE, '0, '0, '0, '0, '0, '0, '0, 3'd0));
    // no active lane: load and store both complete at once
    send(make_item(CMD_LOAD, 4'h0, '1, '1, '1, '1, '1, 16'hFFFF, '0));
    send(make_item(CMD_STORE, 4'h0, '0, '0, '0, '0, '0, 16'h0000, '0));
    // all four lanes in one word: single request from lane 0
    send(make_item(CMD_LOAD, 4'hF, 32'hFFFF_FFFC, 32'hFFFF_FFFD, 32'hFFFF_FFFE,
                   32'hFFFF_FFFF, 8'hE4, 16'h1001, '0));
    // store across all spaces, including the unused space code
    send(make_item(CMD_STORE, 4'hF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0004,
                   32'h8000_0000, 8'hE4, 16'h1002, '0));
    // lane 0 idle: same-word lanes are not merged
    send(make_item(CMD_LOAD, 4'hE, 32'hDEAD_BEEF, 32'h1234_5678, 32'h1234_5679,
                   32'h1234_567B, 8'h98, 16'h1003, '0));
    // two lanes in adjacent words
    send(make_item(CMD_LOAD, 4'h3, 32'h0000_0100, 32'h0000_0104, '0, '0, 8'h06,
                   16'h1004, '0));
    // lanes 0 and 2 share a word, inactive lane 1 differs: merged
    send(make_item(CMD_LOAD, 4'h5, 32'h0000_0200, 32'h0000_0300, 32'h0000_0203, '0,
                   8'h11, 16'h1005, '0));
    // fence waits on the table, then everything else is turned away
    send(make_item(CMD_FENCE, '0, '0, '0, '0, '0, '0, 16'hABCD, '0));
    send(make_item(CMD_LOAD, 4'h1, 32'h0000_0040, '0, '0, '0, '0, 16'h2001, '0));
    send(make_item(CMD_STORE, 4'h1, 32'h0000_0040, '0, '0, '0, '0, 16'h2002, '0));
    send(make_item(CMD_FENCE, '0, '0, '0, '0, '0, '0, 16'h2003, '0));
    drain_results();
    // answer every load; the final one drains the table and frees the fence
    answer(3'd0);
    answer(3'd3);
    answer(3'd2);
    answer(3'd2);
    answer(3'd1);
    answer(3'd1);
    answer(3'd1);
    // one more to the freed slot is a stray
    answer(3'd1);

    for (n = 0; n < ITEMS; n++) begin
      steady     = (n >= 150 && n < 220);
      load_burst = (n >= 40 && n < 70);
      if (n == 100) hold_off = 1'b1;
      if (n == 260) drain_results();

      roll = $urandom_range(99);
      if (!load_burst && unanswered_tags.size() > 0 &&
          roll < (unanswered_tags.size() > 6 ? 70 : 40)) begin
        // well-formed: one response per outstanding load request
        idx = $urandom_range(unanswered_tags.size() - 1);
        it  = random_item(CMD_RESPONSE);
        it.response_tag = unanswered_tags[idx];
        unanswered_tags.delete(idx);
      end else begin
        roll = $urandom_range(99);
        if (load_burst) begin
          // no responses and no fences, so the table fills and turns work away
          it = random_item(roll < 65 ? CMD_LOAD : CMD_STORE);
        end else if (roll < 50) begin
          it = random_item(CMD_LOAD);
        end else if (roll < 78) begin
          it = random_item(CMD_STORE);
        end else if (roll < 90) begin
          it = random_item(CMD_FENCE);
        end else begin
          // noise: response with an arbitrary tag
          it = random_item(CMD_RESPONSE);
        end
      end
      send(it);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** load_store_request_tracker: PASSED **");
    end else begin
      $display("** load_store_request_tracker: FAILED **");
    end
    $finish;
  end

endmodule
